// ===== src/vigenere_cipher_stream_core_macros.svh =====
// Assertion helpers for the cipher core; they expect clk and rst_n in scope.
`ifndef VIGENERE_CIPHER_STREAM_CORE_MACROS_SVH
`define VIGENERE_CIPHER_STREAM_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define VCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cipher core check failed");

// Consequence must hold in the cycle after the antecedent.
`define VCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cipher core check failed");

`endif

// ===== src/vcs_pkg.sv =====
package vcs_pkg;

    localparam int unsigned KEY_LEN = 4;

    // Alphabet and case constants
    localparam logic [7:0] ALPHA_FIRST = 8'd97;
    localparam logic [7:0] ALPHA_LAST  = 8'd122;
    localparam logic [7:0] UPPER_FIRST = 8'd65;
    localparam logic [7:0] UPPER_LAST  = 8'd90;
    localparam logic [7:0] CASE_GAP    = 8'd32;
    localparam logic [5:0] ALPHA_SIZE  = 6'd26;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_DECRYPT_MODE = 3'd0;
    localparam logic [2:0] REG_KEY_LETTER_0 = 3'd1;
    localparam logic [2:0] REG_KEY_LETTER_1 = 3'd2;
    localparam logic [2:0] REG_KEY_LETTER_2 = 3'd3;
    localparam logic [2:0] REG_KEY_LETTER_3 = 3'd4;

    // Rotation amount, 0..25
    typedef logic [4:0] shift_t;
    typedef logic [1:0] key_pos_t;

    // (key - 97) mod 26 over the full 7-bit code; key + 33 stays below 161,
    // so six conditional subtractions bring it under 26.
    function automatic shift_t key_shift(input logic [6:0] key);
        logic [7:0] v;
        v = {1'b0, key} + 8'd33;
        for (int i = 0; i < 6; i++)
        begin
            if (v >= {2'b00, ALPHA_SIZE})
            begin
                v = v - {2'b00, ALPHA_SIZE};
            end
        end
        return v[4:0];
    endfunction

endpackage

// ===== src/vigenere_cipher_stream_core.sv =====
// Vigenere byte cipher with a four-letter keyword.
// Input stream (s_axis_*): one text byte per transfer in tdata, tlast marks the
// last byte of a message. Output stream (m_axis_*): the lower-cased byte,
// rotated within a..z when it is a letter, with tlast copied through.
// Configuration: cfg_we/cfg_index/cfg_data write register 0 (decrypt mode)
// or registers 1..4 (keyword letters as lowercase ASCII); write only while idle.
// Path: a byte accepted on s_axis is held in the input register, then in the
// result register, which presents it on m_axis.
// Throughput: one byte per cycle unless m_axis stalls, as the input and result
// registers each take a new byte every cycle; key position update is one small step.
// Reset: clears both stages, key position 0, encrypt mode, keyword "aaaa".
// Stall: when m_axis_tready is low the result holds, the input register fills
// and then s_axis_tready drops until the result is taken.
`include "vigenere_cipher_stream_core_macros.svh"

module vigenere_cipher_stream_core
    import vcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] text_byte
    input  logic       s_axis_tlast,  // last_in
    // Output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] cipher_byte
    output logic       m_axis_tlast,  // last_out
    // Configuration writes
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data
);

    // Configuration state
    logic     decrypt_reg;
    shift_t   key_off_reg [KEY_LEN];
    key_pos_t key_pos_reg;
    key_pos_t key_pos_next;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_letter_reg;
    shift_t     in_off_reg;

    // Result stage
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       s_fire;
    logic       out_load;
    logic [7:0] folded;
    logic       is_letter;
    logic [5:0] pos;
    logic [5:0] sum;
    logic [5:0] wrapped;
    logic [7:0] result_byte;

    // Handshake: the input register frees when its byte moves to the result register
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Fold to lower case and detect letters
    always_comb
    begin
        if (s_axis_tdata >= UPPER_FIRST && s_axis_tdata <= UPPER_LAST)
        begin
            folded = s_axis_tdata + CASE_GAP;
        end
        else
        begin
            folded = s_axis_tdata;
        end
        is_letter = (folded >= ALPHA_FIRST) && (folded <= ALPHA_LAST);
    end

    // Advance key position on letters, restart after the last byte of a message
    always_comb
    begin
        key_pos_next = key_pos_reg;
        if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                key_pos_next = '0;
            end
            else if (is_letter)
            begin
                key_pos_next = key_pos_reg + 2'd1;
            end
        end
    end

    // Configuration registers; keyword letters are stored as rotation amounts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_reg <= 1'b0;
            for (int i = 0; i < KEY_LEN; i++)
            begin
                key_off_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DECRYPT_MODE: decrypt_reg    <= cfg_data[0];
                REG_KEY_LETTER_0: key_off_reg[0] <= key_shift(cfg_data);
                REG_KEY_LETTER_1: key_off_reg[1] <= key_shift(cfg_data);
                REG_KEY_LETTER_2: key_off_reg[2] <= key_shift(cfg_data);
                REG_KEY_LETTER_3: key_off_reg[3] <= key_shift(cfg_data);
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg   <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_pos_reg <= key_pos_next;
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the folded byte and the rotation amount for its key position
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg   <= folded;
            in_last_reg   <= s_axis_tlast;
            in_letter_reg <= is_letter;
            in_off_reg    <= key_off_reg[key_pos_reg];
        end
    end

    // Rotate within a..z
    always_comb
    begin
        pos = 6'(in_byte_reg - ALPHA_FIRST);
        if (decrypt_reg)
        begin
            sum = pos + ALPHA_SIZE - {1'b0, in_off_reg};
        end
        else
        begin
            sum = pos + {1'b0, in_off_reg};
        end
        if (sum >= ALPHA_SIZE)
        begin
            wrapped = sum - ALPHA_SIZE;
        end
        else
        begin
            wrapped = sum;
        end
        if (in_letter_reg)
        begin
            result_byte = {2'b00, wrapped} + ALPHA_FIRST;
        end
        else
        begin
            result_byte = in_byte_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= result_byte;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    `VCS_ASSERT_NEXT(a_last_restarts_key, s_fire && s_axis_tlast, key_pos_reg == 2'd0)
    `VCS_ASSERT_NEXT(a_other_keeps_key, s_fire && !is_letter && !s_axis_tlast,
                     $stable(key_pos_reg))
    `VCS_ASSERT_NOW(a_shift_in_range, in_valid_reg, in_off_reg < ALPHA_SIZE[4:0])
    `VCS_ASSERT_NEXT(a_letter_stays_letter, out_load && in_letter_reg,
                     m_axis_tdata >= ALPHA_FIRST && m_axis_tdata <= ALPHA_LAST)

endmodule

// ===== tb/vigenere_cipher_stream_core_tb.sv =====
`timescale 1ns / 1ps

module vigenere_cipher_stream_core_tb
    import vcs_pkg::*;
();

    // (key - 97) mod 26 kept non-negative: add 130 - 97, since 130 is 5 * 26
    localparam int KEY_BIAS = 33;
    localparam int RANDOM_PHASES = 8;
    localparam int BYTES_PER_PHASE = 225;
    localparam logic [2:0] KEY_REGS [4] = '{REG_KEY_LETTER_0, REG_KEY_LETTER_1,
                                            REG_KEY_LETTER_2, REG_KEY_LETTER_3};

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] cipher;
        logic       last;
    } cipher_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_DECRYPT_MODE;
    logic [6:0] cfg_data = 7'd0;

    // Mirror of the cipher registers and the running key position
    logic       mirror_decrypt = 1'b0;
    logic [6:0] mirror_key [4] = '{7'd97, 7'd97, 7'd97, 7'd97};
    key_pos_t   mirror_key_pos = '0;

    text_item_t  plaintext_q [$];
    cipher_out_t expected_ciphers [$];

    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    int results_checked = 0;
    int settings_used = 0;

    vigenere_cipher_stream_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Fold, rotate letters by the current key letter, advance or restart key position
    function automatic cipher_out_t rotate_text(input logic [7:0] raw, input logic last);
        cipher_out_t res;
        logic [7:0]  folded;
        int          shift;
        int          pos;
        folded = raw;
        if (raw >= UPPER_FIRST && raw <= UPPER_LAST)
        begin
            folded = raw + CASE_GAP;
        end
        if (folded >= ALPHA_FIRST && folded <= ALPHA_LAST)
        begin
            shift = (int'(mirror_key[mirror_key_pos]) + KEY_BIAS) % int'(ALPHA_SIZE);
            pos = int'(folded - ALPHA_FIRST);
            if (mirror_decrypt)
            begin
                pos = (pos + int'(ALPHA_SIZE) - shift) % int'(ALPHA_SIZE);
            end
            else
            begin
                pos = (pos + shift) % int'(ALPHA_SIZE);
            end
            folded = ALPHA_FIRST + 8'(pos);
            mirror_key_pos = mirror_key_pos + 1'b1;
        end
        if (last)
        begin
            mirror_key_pos = '0;
        end
        res.cipher = folded;
        res.last = last;
        return res;
    endfunction

    // Driver: present queued bytes, predict each accepted transfer
    always @(posedge clk)
    begin : drive_text
        text_item_t item;
        logic       accepted;
        if (rst_n)
        begin
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted)
            begin
                expected_ciphers.push_back(rotate_text(s_axis_tdata, s_axis_tlast));
                bytes_sent++;
                if (s_axis_tlast)
                begin
                    messages_sent++;
                end
            end
            if (!s_axis_tvalid || accepted)
            begin
                if (plaintext_q.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item = plaintext_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= item.text;
                    s_axis_tlast <= item.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin : check_cipher
        cipher_out_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_ciphers.size() == 0)
                begin
                    $display("%0t: unexpected output: expected none, actual byte %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_ciphers.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== want.cipher)
                    begin
                        $display("%0t: cipher byte mismatch: expected %02h actual %02h",
                                 $time, want.cipher, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b actual %0b",
                                 $time, want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic push_text(input logic [7:0] text, input logic last);
        text_item_t item;
        item.text = text;
        item.last = last;
        plaintext_q.push_back(item);
    endtask

    // Hold until every queued byte has been sent and every result has come back
    task automatic drain_stream();
        wait (plaintext_q.size() == 0 && !s_axis_tvalid && expected_ciphers.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // Write mode and keyword while the stream is idle
    task automatic program_cipher(input logic decrypt, input logic [6:0] k0,
                                  input logic [6:0] k1, input logic [6:0] k2,
                                  input logic [6:0] k3);
        logic [6:0] keys [4];
        keys = '{k0, k1, k2, k3};
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_DECRYPT_MODE;
        cfg_data <= {6'd0, decrypt};
        @(posedge clk);
        for (int k = 0; k < 4; k++)
        begin
            cfg_index <= KEY_REGS[k];
            cfg_data <= keys[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        mirror_decrypt = decrypt;
        mirror_key = keys;
        settings_used++;
    endtask

    // Mostly letters of either case, some arbitrary bytes; last on the final one
    task automatic queue_message(input int len);
        int         pick;
        logic [7:0] text;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                text = ALPHA_FIRST + 8'($urandom_range(25));
            end
            else if (pick < 70)
            begin
                text = UPPER_FIRST + 8'($urandom_range(25));
            end
            else
            begin
                text = 8'($urandom_range(255));
            end
            push_text(text, i == len - 1);
        end
    endtask

    // Random bytes with random end marks
    task automatic queue_noise(input int len);
        for (int i = 0; i < len; i++)
        begin
            push_text(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin : stimulus
        int         queued;
        int         len;
        logic [6:0] keys [4];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset keyword "aaaa": only case folding, boundaries around the letters
        push_text(8'd65, 1'b0);
        push_text(8'd90, 1'b0);
        push_text(8'd64, 1'b0);
        push_text(8'd91, 1'b0);
        push_text(8'd96, 1'b0);
        push_text(8'd123, 1'b0);
        push_text(8'd0, 1'b0);
        push_text(8'd255, 1'b0);
        push_text(8'd128, 1'b0);
        push_text(8'd127, 1'b1);
        drain_stream();

        // Encrypt with extreme key letters; letter with end mark resets position
        program_cipher(1'b0, 7'd122, 7'd98, 7'd109, 7'd97);
        push_text(8'd97, 1'b0);
        push_text(8'd122, 1'b0);
        push_text(8'd32, 1'b0);
        push_text(8'd65, 1'b0);
        push_text(8'd109, 1'b1);
        push_text(8'd90, 1'b0);
        push_text(8'd0, 1'b1);
        drain_stream();

        // Decrypt, same keyword
        program_cipher(1'b1, 7'd122, 7'd98, 7'd109, 7'd97);
        push_text(8'd97, 1'b0);
        push_text(8'd90, 1'b0);
        push_text(8'd98, 1'b0);
        push_text(8'd121, 1'b1);
        drain_stream();

        // Key letters outside a..z
        program_cipher(1'b0, 7'd0, 7'd127, 7'd96, 7'd123);
        push_text(8'd97, 1'b0);
        push_text(8'd97, 1'b0);
        push_text(8'd97, 1'b0);
        push_text(8'd122, 1'b0);
        push_text(8'd90, 1'b1);
        drain_stream();

        // Random phases: cycle the idle patterns and the keyword settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle_pct = 0; sink_stall_pct = 0; end
                1: begin sender_idle_pct = 53; sink_stall_pct = 0; end
                2: begin sender_idle_pct = 0; sink_stall_pct = 53; end
                default: begin sender_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            for (int k = 0; k < 4; k++)
            begin
                if (ph == 0)
                begin
                    keys[k] = 7'd97;
                end
                else if (ph == 1)
                begin
                    keys[k] = 7'd122;
                end
                else if (ph == 5)
                begin
                    keys[k] = 7'($urandom_range(127));
                end
                else
                begin
                    keys[k] = 7'($urandom_range(122, 97));
                end
            end
            program_cipher(1'($urandom_range(1)), keys[0], keys[1], keys[2], keys[3]);
            queued = 0;
            while (queued < BYTES_PER_PHASE)
            begin
                if ($urandom_range(99) < 85)
                begin
                    len = $urandom_range(12, 1);
                    queue_message(len);
                end
                else
                begin
                    len = $urandom_range(4, 1);
                    queue_noise(len);
                end
                queued += len;
            end
            drain_stream();
        end

        $display("Covered %0d bytes in %0d messages over %0d mode/keyword settings,",
                 bytes_sent, messages_sent, settings_used);
        $display("checked %0d results with %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #5000000;
        $display("Timeout with %0d results still expected", expected_ciphers.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
